>>> rtl/assert_macros.svh
// shared assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every clock outside reset
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

>>> rtl/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;
	localparam int ORDER_COUNT_DEF = 11;
	localparam int POOL_PAGES_DEF = 4096;
	localparam int PAGE_SHIFT_DEF = 12;
	localparam logic [12:0] USED_MAX = 13'd8191;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE = 2'd1,
		OP_ADD = 2'd2
	} op_t;

	// ceil log2 of a page count, 0 for 0 or 1
	function automatic logic [3:0] order_of(input logic [12:0] n);
		logic [12:0] v;
		logic [3:0] b;
		v = n - 13'd1;
		b = 4'd0;
		for (int k = 0; k < 13; k++) begin
			if (v[k]) b = 4'(k + 1);
		end
		if (n <= 13'd1) b = 4'd0;
		return b;
	endfunction
endpackage

>>> rtl/bpa_if.sv
`timescale 1ns / 1ps
interface bpa_req_if;
	logic valid;
	logic ready;
	logic [1:0] operation;
	logic [11:0] page_index;
	logic [12:0] page_count;
	modport source (output valid, operation, page_index, page_count, input ready);
	modport sink (input valid, operation, page_index, page_count, output ready);
endinterface

interface bpa_rsp_if;
	logic valid;
	logic ready;
	logic ok;
	logic [11:0] block_page;
	logic [3:0] block_order;
	logic [12:0] used_page_count;
	modport source (output valid, ok, block_page, block_order, used_page_count, input ready);
	modport sink (input valid, ok, block_page, block_order, used_page_count, output ready);
endinterface

>>> rtl/bpa_bitmap.sv
`timescale 1ns / 1ps
// free bitmap memory: one port, registered read, clearing pass after reset
module bpa_bitmap import bpa_pkg::*; #(
	parameter int DEPTH = 2 * POOL_PAGES_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input logic [AW-1:0] addr,
	input logic wr_en,
	input logic wr_data,
	output logic rd_data,
	output logic clr_busy
);
	logic mem [DEPTH];
	logic [AW:0] clr_q;

	// clearing sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clr_q < (AW+1)'(DEPTH)) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign clr_busy = (clr_q < (AW+1)'(DEPTH));

	// single port access
	always_ff @(posedge clk) begin
		if (clr_busy) begin
			mem[clr_q[AW-1:0]] <= 1'b0;
		end else if (wr_en) begin
			mem[addr] <= wr_data;
		end
		rd_data <= mem[addr];
	end
endmodule

>>> rtl/buddy_page_allocator.sv
`timescale 1ns / 1ps
// channel  | dir | payload
// req      | in  | operation, page_index, page_count
// rsp      | out | ok, block_page, block_order, used_page_count
// one request at a time; all bitmap accesses share a single port with the clearing pass
// allocate walks to the target order, then reads and checks each bit in turn and splits
// free steps up to its order, then reads and checks the buddy at each merge step
// add region carves blocks one by one, stepping base an order at a time between blocks
// after reset a clearing pass over all 2*POOL_PAGES bitmap bits runs before req is ready
// the result waits in an output register; req stays low until it is taken
module buddy_page_allocator import bpa_pkg::*; #(
	parameter int ORDER_COUNT = ORDER_COUNT_DEF,
	parameter int POOL_PAGES = POOL_PAGES_DEF
) (
	input logic clk,
	input logic arst_n,
	bpa_req_if.sink req,
	bpa_rsp_if.source rsp
);
`include "assert_macros.svh"
	localparam int DEPTH = 2 * POOL_PAGES;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = $clog2(POOL_PAGES) + 1;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SPLIT, S_FREE_RD, S_FREE_CHK,
		S_FREE_SET, S_ADD, S_DONE
	} state_t;

	state_t state_q;
	logic [4:0] ord_q, tgt_q;
	logic [PW:0] idx_q;
	logic [PW:0] start_q, end_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] addr;
	logic wr_en, wr_data, rd_data, clr_busy;
	logic [12:0] used_q;
	logic [12:0] sz;
	logic [13:0] sum;
	logic [PW:0] rem, len;
	logic [4:0] cord;

	bpa_bitmap #(.DEPTH(DEPTH)) u_bitmap (
		.clk, .arst_n, .addr, .wr_en, .wr_data, .rd_data, .clr_busy
	);

	// blocks in current order and region carve order
	always_comb begin
		len = (PW+1)'(POOL_PAGES) >> ord_q;
		rem = end_q - start_q;
		cord = 5'(ORDER_COUNT - 1);
		for (int k = ORDER_COUNT - 1; k >= 1; k--) begin
			if (((PW+1)'(1) << k) > rem || (start_q & (((PW+1)'(1) << k) - 1'b1)) != 0)
				cord = 5'(k - 1);
		end
		sz = 13'(1) << rsp.block_order;
		sum = {1'b0, used_q} + {1'b0, sz};
	end

	// bitmap address and write selection
	always_comb begin
		addr = AW'(base_q + AW'(idx_q));
		wr_en = 1'b0;
		wr_data = 1'b0;
		unique case (state_q)
			S_SCAN_CHK: begin wr_en = rd_data; wr_data = 1'b0; end
			// upper half one order below the current block
			S_SPLIT: begin
				addr = AW'(base_q - AW'(len << 1) + AW'((idx_q << 1) | 1'b1));
				wr_en = 1'b1; wr_data = 1'b1;
			end
			S_FREE_CHK: begin
				addr = AW'(base_q + AW'(idx_q ^ 1'b1));
				wr_en = rd_data && (ord_q < 5'(ORDER_COUNT - 1));
			end
			S_FREE_SET: begin wr_en = 1'b1; wr_data = 1'b1; end
			S_FREE_RD: addr = AW'(base_q + AW'(idx_q ^ 1'b1));
			S_ADD: begin
				addr = AW'(base_q + AW'(start_q >> cord));
				wr_en = (start_q < end_q) && (ord_q == cord); wr_data = 1'b1;
			end
			default: ;
		endcase
	end

	assign req.ready = (state_q == S_IDLE) && !clr_busy;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			rsp.valid <= 1'b0;
			rsp.ok <= 1'b0;
			rsp.block_page <= '0;
			rsp.block_order <= '0;
			ord_q <= '0;
			tgt_q <= '0;
			idx_q <= '0;
			start_q <= '0;
			end_q <= '0;
			base_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					base_q <= '0;
					ord_q <= 5'd0;
					case (req.operation)
						OP_ALLOC: begin
							rsp.ok <= 1'b0;
							rsp.block_page <= '0;
							rsp.block_order <= order_of(req.page_count);
							tgt_q <= 5'(order_of(req.page_count));
							idx_q <= '0;
							if (req.page_count == 0 ||
								5'(order_of(req.page_count)) >= 5'(ORDER_COUNT))
								state_q <= S_DONE;
							else
								state_q <= S_SCAN_RD;
						end
						OP_FREE: begin
							rsp.ok <= 1'b1;
							rsp.block_page <= '0;
							rsp.block_order <= order_of(req.page_count);
							tgt_q <= 5'(order_of(req.page_count));
							idx_q <= (PW+1)'(req.page_index) >> order_of(req.page_count);
							state_q <= S_FREE_RD;
						end
						OP_ADD: begin
							rsp.ok <= 1'b1;
							rsp.block_page <= '0;
							rsp.block_order <= '0;
							start_q <= (PW+1)'(req.page_index);
							if (32'(req.page_index) >= 32'(POOL_PAGES))
								end_q <= '0;
							else if ((PW+1)'(req.page_index) + (PW+1)'(req.page_count)
								> (PW+1)'(POOL_PAGES))
								end_q <= (PW+1)'(POOL_PAGES);
							else
								end_q <= (PW+1)'(req.page_index) + (PW+1)'(req.page_count);
							state_q <= S_ADD;
						end
						default: begin
							rsp.ok <= 1'b0;
							rsp.block_page <= '0;
							rsp.block_order <= '0;
							state_q <= S_DONE;
						end
					endcase
				end
				// walk base up to target order, then scan bits
				S_SCAN_RD: begin
					if (ord_q < tgt_q) begin
						base_q <= base_q + AW'(len);
						ord_q <= ord_q + 1'b1;
					end else if (ord_q >= 5'(ORDER_COUNT)) begin
						state_q <= S_DONE;
					end else if (idx_q >= len) begin
						base_q <= base_q + AW'(len);
						ord_q <= ord_q + 1'b1;
						idx_q <= '0;
					end else begin
						state_q <= S_SCAN_CHK;
					end
				end
				S_SCAN_CHK: begin
					if (rd_data) begin
						rsp.ok <= 1'b1;
						used_q <= sum > 14'(USED_MAX) ? USED_MAX : sum[12:0];
						if (ord_q == tgt_q) begin
							rsp.block_page <= 12'(idx_q << tgt_q);
							state_q <= S_DONE;
						end else begin
							state_q <= S_SPLIT;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				// free upper halves down to target
				S_SPLIT: begin
					ord_q <= ord_q - 1'b1;
					idx_q <= idx_q << 1;
					base_q <= base_q - AW'((PW+1)'(POOL_PAGES) >> (ord_q - 1'b1));
					if (ord_q == tgt_q + 5'd1) begin
						rsp.block_page <= 12'((idx_q << 1) << tgt_q);
						state_q <= S_DONE;
					end
				end
				// free: walk base to order, drop blocks out of range
				S_FREE_RD: begin
					if (ord_q >= 5'(ORDER_COUNT) || idx_q >= len) begin
						if (used_q >= sz) used_q <= used_q - sz;
						state_q <= S_DONE;
					end else if (ord_q < tgt_q) begin
						base_q <= base_q + AW'(len);
						ord_q <= ord_q + 1'b1;
					end else begin
						state_q <= S_FREE_CHK;
					end
				end
				S_FREE_CHK: begin
					if (rd_data && ord_q < 5'(ORDER_COUNT - 1)) begin
						base_q <= base_q + AW'(len);
						ord_q <= ord_q + 1'b1;
						idx_q <= idx_q >> 1;
						state_q <= S_FREE_RD;
					end else begin
						state_q <= S_FREE_SET;
					end
				end
				S_FREE_SET: begin
					if (used_q >= sz) used_q <= used_q - sz;
					state_q <= S_DONE;
				end
				// carve one block per cycle while base sits at the carve order, else walk base toward it
				S_ADD: begin
					if (start_q >= end_q) begin
						state_q <= S_DONE;
					end else if (ord_q != cord) begin
						if (ord_q < cord) begin
							base_q <= base_q + AW'(len);
							ord_q <= ord_q + 1'b1;
						end else begin
							base_q <= base_q - AW'((PW+1)'(POOL_PAGES) >> (ord_q - 1'b1));
							ord_q <= ord_q - 1'b1;
						end
					end else begin
						start_q <= start_q + ((PW+1)'(1) << cord);
					end
				end
				S_DONE: begin
					if (!rsp.valid) rsp.valid <= 1'b1;
					else if (rsp.ready) begin
						rsp.valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.used_page_count = used_q;

	`ASSERT_IMP(a_no_ready_busy, clk, arst_n, state_q != S_IDLE, !req.ready)
	`ASSERT_IMP(a_valid_done, clk, arst_n, rsp.valid, state_q == S_DONE)
	`ASSERT_IMP(a_fail_zero, clk, arst_n, rsp.valid && !rsp.ok, rsp.block_page == 12'd0)
	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp.valid && !rsp.ready, rsp.valid)
endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
module tb;
	import bpa_pkg::*;

	localparam int ORDERS = ORDER_COUNT_DEF;
	localparam int POOL = POOL_PAGES_DEF;
	localparam int BITMAP_BITS = 2 * POOL;
	localparam int RANDOM_REQUESTS = 600;
	localparam longint CYCLE_LIMIT = 50_000_000;
	localparam logic [1:0] OP_BAD = 2'd3;

	typedef struct {
		bit free_bits[BITMAP_BITS];
		logic [12:0] used;
	} pool_state_t;

	typedef struct packed {
		logic ok;
		logic [11:0] block_page;
		logic [3:0] block_order;
		logic [12:0] used_page_count;
	} outcome_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [11:0] page_index;
		logic [12:0] page_count;
		bit drain;
	} request_t;

	typedef struct packed {
		logic [11:0] page;
		logic [3:0] order;
	} live_block_t;

	logic clk;
	logic arst_n;
	bpa_req_if req_ch();
	bpa_rsp_if rsp_ch();

	buddy_page_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	pool_state_t alloc_model;
	pool_state_t plan_pool;
	request_t pending_reqs[$];
	outcome_t expected_outcomes[$];
	live_block_t live_blocks[$];
	int unsigned accepted_n;
	int unsigned checked_n;
	int unsigned errors;
	int unsigned grants;
	int unsigned refusals;
	longint cycles;

	// bitmap helpers, one level per order
	function automatic int level_base(int o);
		return BITMAP_BITS - (BITMAP_BITS >> o);
	endfunction

	function automatic bit bit_read(const ref pool_state_t p, input int o, input int i);
		if (o >= ORDERS || i >= (POOL >> o)) return 1'b0;
		return p.free_bits[level_base(o) + i];
	endfunction

	function automatic void bit_write(ref pool_state_t p, input int o, input int i,
			input bit v);
		if (o >= ORDERS || i >= (POOL >> o)) return;
		p.free_bits[level_base(o) + i] = v;
	endfunction

	function automatic int pages_to_order(int n);
		int b;
		int v;
		b = 0;
		if (n <= 1) return 0;
		v = n - 1;
		while (v != 0) begin
			b++;
			v = v >> 1;
		end
		return b;
	endfunction

	function automatic void pool_clear(ref pool_state_t p);
		for (int k = 0; k < BITMAP_BITS; k++) p.free_bits[k] = 1'b0;
		p.used = '0;
	endfunction

	// one request applied to the allocator state
	function automatic outcome_t run_request(ref pool_state_t p, input request_t r);
		outcome_t res;
		int o;
		int i;
		int start;
		int stop;
		int sum;
		bit found;
		res = '0;
		case (r.operation)
			OP_ALLOC: begin
				if (r.page_count != 0) begin
					o = pages_to_order(int'(r.page_count));
					res.block_order = 4'(o);
					found = 1'b0;
					i = 0;
					// lowest order first, lowest index within an order
					while (o < ORDERS && !found) begin
						for (i = 0; i < (POOL >> o); i++) begin
							if (p.free_bits[level_base(o) + i]) begin
								found = 1'b1;
								break;
							end
						end
						if (!found) o++;
					end
					if (found) begin
						bit_write(p, o, i, 1'b0);
						// split down, upper halves become free
						while (o > int'(res.block_order)) begin
							o--;
							i = i << 1;
							bit_write(p, o, i + 1, 1'b1);
						end
						res.block_page = 12'(i << o);
						sum = int'(p.used) + (1 << o);
						p.used = (sum > int'(USED_MAX)) ? USED_MAX : 13'(sum);
						res.ok = 1'b1;
					end
				end
			end
			OP_FREE: begin
				o = pages_to_order(int'(r.page_count));
				res.block_order = 4'(o);
				if (o < ORDERS && (int'(r.page_index) >> o) < (POOL >> o)) begin
					i = int'(r.page_index) >> o;
					// merge with free buddies
					while (o < ORDERS - 1) begin
						if (!bit_read(p, o, i ^ 1)) break;
						bit_write(p, o, i ^ 1, 1'b0);
						i = i >> 1;
						o++;
					end
					bit_write(p, o, i, 1'b1);
				end
				if (int'(p.used) >= (1 << pages_to_order(int'(r.page_count))))
					p.used = p.used - 13'(1 << pages_to_order(int'(r.page_count)));
				res.ok = 1'b1;
			end
			OP_ADD: begin
				start = int'(r.page_index);
				stop = start + int'(r.page_count);
				if (stop > POOL) stop = POOL;
				// largest aligned blocks, no merging
				while (start < stop) begin
					o = ORDERS - 1;
					while (o > 0 && (1 << o) > stop - start) o--;
					while (o > 0 && (start & ((1 << o) - 1)) != 0) o--;
					bit_write(p, o, start >> o, 1'b1);
					start += 1 << o;
				end
				res.ok = 1'b1;
			end
			default: ;
		endcase
		res.used_page_count = p.used;
		return res;
	endfunction

	// queue a request and track what it does to a planning copy of the pool
	task automatic plan(input logic [1:0] op, input int idx, input int cnt,
			input bit drain = 1'b0);
		request_t r;
		outcome_t res;
		r.operation = op;
		r.page_index = 12'(idx);
		r.page_count = 13'(cnt);
		r.drain = drain;
		res = run_request(plan_pool, r);
		if (op == OP_ALLOC && res.ok)
			live_blocks.push_back('{page: res.block_page, order: res.block_order});
		pending_reqs.push_back(r);
	endtask

	// return one block that the plan shows as allocated
	task automatic plan_release();
		int k;
		int o;
		int cnt;
		int idx;
		live_block_t b;
		k = $urandom_range(0, live_blocks.size() - 1);
		b = live_blocks[k];
		live_blocks.delete(k);
		o = int'(b.order);
		cnt = (o == 0) ? $urandom_range(0, 1) : $urandom_range((1 << (o - 1)) + 1, 1 << o);
		idx = int'(b.page);
		// occasionally misaligned inside the block
		if (o > 0 && $urandom_range(0, 9) == 0) idx += $urandom_range(1, (1 << o) - 1);
		plan(OP_FREE, idx, cnt);
	endtask

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_ALLOC;
		req_ch.page_index = '0;
		req_ch.page_count = '0;
		rsp_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request driver, bursts and gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			accepted_n <= 0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				request_t acc;
				acc.operation = req_ch.operation;
				acc.page_index = req_ch.page_index;
				acc.page_count = req_ch.page_count;
				acc.drain = 1'b0;
				expected_outcomes.push_back(run_request(alloc_model, acc));
				accepted_n <= accepted_n + 1;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					req_ch.valid <= 1'b0;
				end else if (pending_reqs.size() != 0 && !(pending_reqs[0].drain &&
						(req_ch.valid || accepted_n != checked_n))) begin
					request_t nx;
					nx = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.operation <= nx.operation;
					req_ch.page_index <= nx.page_index;
					req_ch.page_count <= nx.page_count;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response stall pattern with one long hold
	int mode;
	int mode_left;
	int hold_left;
	bit hold_done;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			mode <= 0;
			mode_left <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!hold_done && checked_n >= 150) begin
			hold_done <= 1'b1;
			hold_left <= 600;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(50, 300);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (mode)
				0: rsp_ch.ready <= 1'b1;
				1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
				default: rsp_ch.ready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	// response checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			checked_n <= 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			checked_n <= checked_n + 1;
			if (expected_outcomes.size() == 0) begin
				errors++;
				$display("%0t: response with nothing outstanding: ok=%0b page=%0d", $time,
					rsp_ch.ok, rsp_ch.block_page);
			end else begin
				outcome_t e;
				e = expected_outcomes.pop_front();
				if (rsp_ch.ok !== e.ok) begin
					errors++;
					$display("%0t: ok expected %0b got %0b", $time, e.ok, rsp_ch.ok);
				end
				if (rsp_ch.block_page !== e.block_page) begin
					errors++;
					$display("%0t: block_page expected %0d got %0d", $time, e.block_page,
						rsp_ch.block_page);
				end
				if (rsp_ch.block_order !== e.block_order) begin
					errors++;
					$display("%0t: block_order expected %0d got %0d", $time, e.block_order,
						rsp_ch.block_order);
				end
				if (rsp_ch.used_page_count !== e.used_page_count) begin
					errors++;
					$display("%0t: used_page_count expected %0d got %0d", $time,
						e.used_page_count, rsp_ch.used_page_count);
				end
				if (e.ok) grants++;
				else refusals++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// stimulus plan and end of run
	initial begin
		int r;
		int c;
		cycles = 0;
		errors = 0;
		grants = 0;
		refusals = 0;
		pool_clear(alloc_model);
		pool_clear(plan_pool);

		// free with nothing used, alloc from an empty pool, then seed the whole pool
		plan(OP_FREE, 0, 8);
		plan(OP_ALLOC, 0, 1);
		plan(OP_ADD, 0, POOL);
		plan(OP_ALLOC, 0, 0);
		plan(OP_ALLOC, 0, 1);
		plan(OP_ALLOC, 0, 3);
		plan(OP_ALLOC, 0, 4096);
		plan(OP_ALLOC, 0, 8191);
		plan(OP_ALLOC, 0, 2048);
		plan(OP_FREE, 5, 4);
		plan(OP_FREE, 4, 3);
		plan(OP_FREE, 0, 4096);
		plan(OP_FREE, 4095, 8191);
		plan(OP_ADD, 4000, 8191);
		plan(OP_ADD, 4095, 1);
		plan(OP_ADD, 4095, 0);
		plan(OP_BAD, 4095, 8191);
		// drive the used count into saturation
		for (int k = 0; k < 3; k++) begin
			plan(OP_ADD, 0, POOL);
			repeat (4) plan(OP_ALLOC, 4095, 1024);
		end
		plan(OP_FREE, 2048, 1024, 1'b1);
		live_blocks.delete();
		plan(OP_ADD, 0, POOL);

		// mostly alloc/free pairs with random content, some noise
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			r = $urandom_range(0, 99);
			if (n == RANDOM_REQUESTS / 2) begin
				plan(OP_ALLOC, 0, $urandom_range(1, 8), 1'b1);
			end else if ((r < 45 && live_blocks.size() < 150) || live_blocks.size() == 0) begin
				c = $urandom_range(0, 99);
				if (c < 85) c = $urandom_range(1, 16);
				else if (c < 95) c = $urandom_range(17, 1024);
				else c = $urandom_range(0, 8191);
				plan(OP_ALLOC, $urandom_range(0, 4095), c);
			end else if (r < 82) begin
				plan_release();
			end else if (r < 90) begin
				plan(OP_ADD, $urandom_range(0, 4095),
					($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 300));
			end else if (r < 96) begin
				plan(OP_FREE, $urandom_range(0, 4095), $urandom_range(0, 64));
			end else begin
				plan(OP_BAD, $urandom_range(0, 4095), $urandom_range(0, 8191));
			end
		end

		@(posedge arst_n);
		while (pending_reqs.size() != 0 || req_ch.valid || accepted_n != checked_n)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (expected_outcomes.size() != 0) begin
			errors++;
			$display("%0t: %0d responses never arrived", $time, expected_outcomes.size());
		end
		$display("%0d requests checked: %0d done, %0d refused or rejected", checked_n, grants,
			refusals);
		$display("covered region carving, split allocation, buddy merging and count limits");
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

>>> filelist.f
+incdir+rtl
rtl/bpa_pkg.sv
rtl/bpa_if.sv
rtl/bpa_bitmap.sv
rtl/buddy_page_allocator.sv
verif/tb.sv
